// ===== hdl/screlu_dot_product_output_top_macros.svh =====
// Assertion macros shared by the SCReLU output layer RTL.
`ifndef SCRELU_DOT_PRODUCT_OUTPUT_TOP_MACROS_SVH
`define SCRELU_DOT_PRODUCT_OUTPUT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising edge of clk while rst_n is high.
`define SDPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property on every rising edge of clk, reset included.
`define SDPO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDPO_ASSERT(lbl, prop, msg)
`define SDPO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/sdpo_pkg.sv =====
// Shared types, constants and functions of the SCReLU output layer.
`timescale 1ns / 1ps
`default_nettype none
package sdpo_pkg;

  localparam int HIDDEN_SIZE_DEF  = 1024;
  localparam int BUCKET_COUNT_DEF = 8;

  localparam int ACT_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int CLIP_W   = 15;
  localparam int BUCKET_W = 3;
  localparam int INDEX_W  = 10;
  localparam int SCORE_W  = 32;
  localparam int ENTRY_W  = 2 * WEIGHT_W;

  localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd255;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_ACC   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;       // weight pair transfer: write the weight RAM
    logic capture;  // activation pair transfer: read RAM, latch clamped acts
    logic mul1;     // weight times clamped activation, keep low 16 bits
    logic mul2;     // truncated product times clamped activation
    logic acc;      // add both terms, emit and clear on last
  } sdpo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // item in flight ends an evaluation
    logic out_block;  // output register holds a score that is not taken now
  } sdpo_sts_t;

  // Clamps a signed activation into [0, clip].
  function automatic logic [CLIP_W-1:0] clamp_act(input logic [ACT_W-1:0] a,
                                                  input logic [CLIP_W-1:0] clip);
    logic [CLIP_W-1:0] res;
    if (a[ACT_W-1]) begin
      res = '0;
    end else if (a[CLIP_W-1:0] > clip) begin
      res = clip;
    end else begin
      res = a[CLIP_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/screlu_dot_product_output_top.sv =====
// Top level of the SCReLU output layer: controller, datapath and ports.
`timescale 1ns / 1ps
`default_nettype none
// Bucketed NNUE output layer. A transfer with in_mode 0 writes a weight pair into the
// weight RAM, and the next item is taken in the cycle after. A transfer with in_mode 1
// steps through the weight RAM read, the weight-times-activation stage, the
// truncated-product-times-activation stage and the accumulate, and no new item is taken
// until that accumulate is done, so the two serial multiplier stages behind the registered
// RAM read set the accumulate rate. An item marked last loads its score into the output
// register; if an earlier score there is still not taken, that item holds in its
// accumulate cycle until it is. The weight RAM is not cleared after reset: every entry
// must be written before it is used. clip_r resets to 255 and is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, as the block has no guard.
module screlu_dot_product_output_top
  import sdpo_pkg::*;
#(
  parameter int HIDDEN_SIZE  = HIDDEN_SIZE_DEF,
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic        [CLIP_W-1:0]   cfg_wdata,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       in_mode,
  input  wire logic        [BUCKET_W-1:0] in_bucket,
  input  wire logic        [INDEX_W-1:0]  in_index,
  input  wire logic signed [WEIGHT_W-1:0] in_us_weight,
  input  wire logic signed [WEIGHT_W-1:0] in_them_weight,
  input  wire logic signed [ACT_W-1:0]    in_us_act,
  input  wire logic signed [ACT_W-1:0]    in_them_act,
  input  wire logic                       in_last,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic signed [SCORE_W-1:0]  out_score
);

  sdpo_cmd_t cmd;
  sdpo_sts_t sts;

  sdpo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdpo_dpath #(
    .HIDDEN_SIZE  (HIDDEN_SIZE),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_bucket      (in_bucket),
    .in_index       (in_index),
    .in_us_weight   (in_us_weight),
    .in_them_weight (in_them_weight),
    .in_us_act      (in_us_act),
    .in_them_act    (in_them_act),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_score      (out_score)
  );

endmodule
`default_nettype wire

// ===== hdl/sdpo_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sdpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/sdpo_ctrl.sv =====
// Controller state machine that sequences one item at a time through the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "screlu_dot_product_output_top_macros.svh"
module sdpo_ctrl
  import sdpo_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_mode,
  output      logic      in_ready,
  input  wire sdpo_sts_t sts,
  output      sdpo_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd         = '0;
    cmd.wr      = accept & (in_mode == MODE_WRITE);
    cmd.capture = accept & (in_mode == MODE_ACC);
    cmd.mul1    = (state_r == S_MUL1);
    cmd.mul2    = (state_r == S_MUL2);
    // A last item waits here until the previous score has been taken.
    cmd.acc     = (state_r == S_ACC) & ~(sts.last & sts.out_block);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (cmd.acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SDPO_ASSERT(a_acc_starts, cmd.capture |=> state_r == S_MUL1, "accumulate did not start")
  `SDPO_ASSERT(a_mul_chain, state_r == S_MUL1 |=> state_r == S_MUL2 ##1 state_r == S_ACC,
               "multiplier sequence broken")
  `SDPO_ASSERT(a_stall_cause, (state_r == S_ACC) && !cmd.acc |-> sts.last && sts.out_block,
               "accumulate stalled without a waiting score")

endmodule
`default_nettype wire

// ===== hdl/sdpo_dpath.sv =====
// Datapath: weight RAM, clamps, two multiplier stages, accumulator and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "screlu_dot_product_output_top_macros.svh"
module sdpo_dpath
  import sdpo_pkg::*;
#(
  parameter int HIDDEN_SIZE  = HIDDEN_SIZE_DEF,
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic        [CLIP_W-1:0]   cfg_wdata,
  input  wire logic        [BUCKET_W-1:0] in_bucket,
  input  wire logic        [INDEX_W-1:0]  in_index,
  input  wire logic signed [WEIGHT_W-1:0] in_us_weight,
  input  wire logic signed [WEIGHT_W-1:0] in_them_weight,
  input  wire logic signed [ACT_W-1:0]    in_us_act,
  input  wire logic signed [ACT_W-1:0]    in_them_act,
  input  wire logic                       in_last,
  input  wire sdpo_cmd_t                  cmd,
  output      sdpo_sts_t                  sts,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic signed [SCORE_W-1:0]  out_score
);

  localparam int DEPTH = BUCKET_COUNT * HIDDEN_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic              in_range;
  logic [AW-1:0]     addr;
  logic [ENTRY_W-1:0] rd_data;

  logic [CLIP_W-1:0] clip_r;
  logic [CLIP_W-1:0] us_c_r;
  logic [CLIP_W-1:0] them_c_r;
  logic              last_r;
  logic              in_range_r;

  logic [WEIGHT_W-1:0] w_us;
  logic [WEIGHT_W-1:0] w_them;
  logic [15:0]         p16_us_nxt;
  logic [15:0]         p16_them_nxt;
  logic [15:0]         p16_us_r;
  logic [15:0]         p16_them_r;

  logic [SCORE_W-1:0] term_us_nxt;
  logic [SCORE_W-1:0] term_them_nxt;
  logic [SCORE_W-1:0] term_us_r;
  logic [SCORE_W-1:0] term_them_r;

  logic [SCORE_W-1:0] sum_r;
  logic [SCORE_W-1:0] sum_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [SCORE_W-1:0] out_score_r;

  assign in_range = (32'(in_bucket) < 32'(BUCKET_COUNT)) && (32'(in_index) < 32'(HIDDEN_SIZE));
  assign addr     = AW'(in_bucket) * AW'(HIDDEN_SIZE) + AW'(in_index);

  sdpo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (cmd.wr & in_range),
    .waddr (addr),
    .wdata ({in_them_weight, in_us_weight}),
    .re    (cmd.capture),
    .raddr (addr),
    .rdata (rd_data)
  );

  // An out-of-range index reads as a zero weight pair.
  assign w_us   = in_range_r ? rd_data[WEIGHT_W-1:0]       : '0;
  assign w_them = in_range_r ? rd_data[ENTRY_W-1:WEIGHT_W] : '0;

  // Low bits of a product do not depend on signedness.
  assign p16_us_nxt   = 16'({16'b0, w_us}   * {17'b0, us_c_r});
  assign p16_them_nxt = 16'({16'b0, w_them} * {17'b0, them_c_r});

  assign term_us_nxt   = SCORE_W'($signed({{16{p16_us_r[15]}}, p16_us_r}) *
                                  $signed({17'b0, us_c_r}));
  assign term_them_nxt = SCORE_W'($signed({{16{p16_them_r[15]}}, p16_them_r}) *
                                  $signed({17'b0, them_c_r}));

  assign sum_nxt = sum_r + term_us_r + term_them_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.acc && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r      <= CLIP_RESET;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        clip_r <= cfg_wdata;
      end
      if (cmd.acc) begin
        sum_r <= last_r ? '0 : sum_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      us_c_r     <= clamp_act(in_us_act, clip_r);
      them_c_r   <= clamp_act(in_them_act, clip_r);
      last_r     <= in_last;
      in_range_r <= in_range;
    end
    if (cmd.mul1) begin
      p16_us_r   <= p16_us_nxt;
      p16_them_r <= p16_them_nxt;
    end
    if (cmd.mul2) begin
      term_us_r   <= term_us_nxt;
      term_them_r <= term_them_nxt;
    end
    if (cmd.acc && last_r) begin
      out_score_r <= sum_nxt;
    end
  end

  assign sts.last      = last_r;
  assign sts.out_block = out_valid_r & ~out_ready;
  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;

  `SDPO_ASSERT(a_last_emits, cmd.acc && last_r |=> out_valid_r && (sum_r == '0),
               "last item did not emit and clear")
  `SDPO_ASSERT(a_sum_adds, cmd.acc && !last_r |=> sum_r == $past(sum_nxt),
               "accumulator missed an update")
  `SDPO_ASSERT(a_range_zero, cmd.mul1 && !in_range_r |=> (p16_us_r == '0) && (p16_them_r == '0),
               "out-of-range index produced a nonzero term")

endmodule
`default_nettype wire
